// ===== sv/pcc_pkg.sv =====
`timescale 1ns / 1ps

package pcc_pkg;

  typedef enum logic [1:0] {
    MODE_ADJUST   = 2'd0,
    MODE_TIMER    = 2'd1,
    MODE_PAUSED   = 2'd2,
    MODE_FINISHED = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PH_FOCUS = 2'd0,
    PH_SHORT = 2'd1,
    PH_LONG  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_BUTTON = 2'd1,
    CMD_NEXT   = 2'd2,
    CMD_INC    = 2'd3
  } cmd_t;

  // register indexes, taken from paddr[2]
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_LIMIT    = 1'b1;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd200;
  localparam logic [3:0]  LIMIT_RESET    = 4'd3;

  localparam logic [6:0] SEC_TOP    = 7'd59;
  localparam logic [3:0] DIGIT_BASE = 4'd10;
  localparam logic [1:0] EDIT_TOP   = 2'd3;

  localparam logic [6:0] DUR_FOCUS_MIN = 7'd25;
  localparam logic [6:0] DUR_SHORT_MIN = 7'd5;
  localparam logic [6:0] DUR_LONG_MIN  = 7'd15;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [3:0]  short_breaks_before_long;
  } cfg_t;

  typedef struct packed {
    logic [6:0] minutes;
    logic [6:0] seconds;
  } dur_t;

  typedef struct packed {
    mode_t      run_mode;
    phase_t     phase;
    logic [6:0] minutes_left;
    logic [6:0] seconds_left;
    logic [6:0] edit_minutes;
    logic [6:0] edit_seconds;
    logic [1:0] edit_position;
    logic       mode_changed;
  } result_t;

  // quotient by ten for values below 128, by reciprocal 205/2048
  function automatic logic [3:0] div10(input logic [6:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] mod10(input logic [6:0] v);
    logic [6:0] q10;
    q10 = 7'(div10(v)) * 7'(DIGIT_BASE);
    return 4'(v - q10);
  endfunction

  // tens * 10 + units, kept to 7 bits
  function automatic logic [6:0] edit_value(input logic [3:0] tens, input logic [3:0] units);
    logic [7:0] s;
    s = 8'(tens) * 8'(DIGIT_BASE) + 8'(units);
    return s[6:0];
  endfunction

endpackage

// ===== sv/pcc_cfg.sv =====
`timescale 1ns / 1ps

module pcc_cfg import pcc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms              <= DEBOUNCE_RESET;
      cfg.short_breaks_before_long <= LIMIT_RESET;
    end else if (wr) begin
      case (paddr[2])
        REG_DEBOUNCE: cfg.debounce_ms              <= pwdata[15:0];
        REG_LIMIT:    cfg.short_breaks_before_long <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DEBOUNCE: prdata = {16'd0, cfg.debounce_ms};
      REG_LIMIT:    prdata = {28'd0, cfg.short_breaks_before_long};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

// ===== sv/pcc_in_stage.sv =====
`timescale 1ns / 1ps

module pcc_in_stage import pcc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,
  input  logic [31:0] s_tdata,
  input  logic        advance,
  output logic        item_valid,
  output cmd_t        item_cmd,
  output logic [31:0] item_time
);

  // register frees when the core takes its item
  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item_cmd  <= cmd_t'(s_tuser);
      item_time <= s_tdata;
    end
  end

endmodule

// ===== sv/pcc_core.sv =====
`timescale 1ns / 1ps

module pcc_core import pcc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        item_valid,
  input  cmd_t        item_cmd,
  input  logic [31:0] item_time,
  output logic        advance,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_result
);

  mode_t       mode, mode_next;
  phase_t      phase, phase_next;
  logic [6:0]  count_minutes, count_minutes_next;
  logic [6:0]  count_seconds, count_seconds_next;
  dur_t        durations [3];
  dur_t        durations_next [3];
  logic [3:0]  digits [4];
  logic [3:0]  digits_next [4];
  logic [1:0]  edit_index, edit_index_next;
  logic [3:0]  tally, tally_next;
  logic [31:0] last_next_touch, last_next_touch_next;
  logic [31:0] last_inc_touch, last_inc_touch_next;
  logic        step;
  logic        next_ok, inc_ok;
  logic        do_store, do_load, do_adjust;
  logic [6:0]  edit_min, edit_sec;
  result_t     result_next;

  assign advance = !out_valid || out_ready;
  assign step    = item_valid && advance;

  assign edit_min = edit_value(digits[3], digits[2]);
  assign edit_sec = edit_value(digits[1], digits[0]);

  assign next_ok = (item_time - last_next_touch) > 32'(cfg.debounce_ms);
  assign inc_ok  = (item_time - last_inc_touch)  > 32'(cfg.debounce_ms);

  // next state
  always_comb begin
    mode_next            = mode;
    phase_next           = phase;
    count_minutes_next   = count_minutes;
    count_seconds_next   = count_seconds;
    durations_next       = durations;
    digits_next          = digits;
    edit_index_next      = edit_index;
    tally_next           = tally;
    last_next_touch_next = last_next_touch;
    last_inc_touch_next  = last_inc_touch;
    do_store             = 1'b0;
    do_load              = 1'b0;
    do_adjust            = 1'b0;

    case (mode)
      MODE_TIMER: begin
        if (item_cmd == CMD_TICK) begin
          if (count_seconds != 7'd0) begin
            count_seconds_next = count_seconds - 7'd1;
          end else if (count_minutes != 7'd0) begin
            count_minutes_next = count_minutes - 7'd1;
            count_seconds_next = SEC_TOP;
          end else begin
            mode_next = MODE_FINISHED;
          end
        end else if (item_cmd == CMD_BUTTON) begin
          mode_next = MODE_PAUSED;
        end
        if (count_minutes_next == 7'd0 && count_seconds_next == 7'd0) begin
          mode_next = MODE_FINISHED;
        end
      end
      MODE_FINISHED: begin
        if (item_cmd != CMD_TICK) begin
          if (phase == PH_FOCUS) begin
            if (tally < cfg.short_breaks_before_long) begin
              phase_next = PH_SHORT;
              tally_next = tally + 4'd1;
            end else begin
              phase_next = PH_LONG;
              tally_next = 4'd0;
            end
          end else begin
            phase_next = PH_FOCUS;
          end
          do_load   = 1'b1;
          mode_next = MODE_TIMER;
        end
      end
      MODE_ADJUST: begin
        case (item_cmd)
          CMD_BUTTON: begin
            do_store  = 1'b1;
            do_load   = 1'b1;
            mode_next = MODE_TIMER;
          end
          CMD_NEXT: begin
            if (next_ok) begin
              last_next_touch_next = item_time;
              if (edit_index != 2'd0) begin
                edit_index_next = edit_index - 2'd1;
              end else begin
                do_store  = 1'b1;
                do_adjust = 1'b1;
                case (phase)
                  PH_FOCUS: phase_next = PH_SHORT;
                  PH_SHORT: phase_next = PH_LONG;
                  default:  phase_next = PH_FOCUS;
                endcase
              end
            end
          end
          CMD_INC: begin
            if (inc_ok) begin
              last_inc_touch_next = item_time;
              if (digits[edit_index] + 4'd1 >= DIGIT_BASE) begin
                digits_next[edit_index] = 4'd0;
              end else begin
                digits_next[edit_index] = digits[edit_index] + 4'd1;
              end
            end
          end
          default: ;
        endcase
      end
      default: begin
        // paused
        if (item_cmd == CMD_BUTTON) begin
          mode_next = MODE_TIMER;
        end else if (item_cmd != CMD_TICK) begin
          phase_next = PH_FOCUS;
          do_adjust  = 1'b1;
        end
      end
    endcase

    // store goes first so a load of the same slot sees the new value
    if (do_store) begin
      durations_next[phase] = '{minutes: edit_min, seconds: edit_sec};
    end
    if (do_load || do_adjust) begin
      count_minutes_next = durations_next[phase_next].minutes;
      count_seconds_next = durations_next[phase_next].seconds;
    end
    if (do_adjust) begin
      mode_next       = MODE_ADJUST;
      digits_next[0]  = mod10(count_seconds_next);
      digits_next[1]  = div10(count_seconds_next);
      digits_next[2]  = mod10(count_minutes_next);
      digits_next[3]  = div10(count_minutes_next);
      edit_index_next = EDIT_TOP;
    end
  end

  // result
  always_comb begin
    result_next.run_mode      = mode_next;
    result_next.phase         = phase_next;
    result_next.minutes_left  = count_minutes_next;
    result_next.seconds_left  = count_seconds_next;
    result_next.edit_minutes  = edit_value(digits_next[3], digits_next[2]);
    result_next.edit_seconds  = edit_value(digits_next[1], digits_next[0]);
    result_next.edit_position = edit_index_next;
    result_next.mode_changed  = (mode_next != mode) || (phase_next != phase);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode               <= MODE_ADJUST;
      phase              <= PH_FOCUS;
      count_minutes      <= DUR_FOCUS_MIN;
      count_seconds      <= 7'd0;
      durations[0]       <= '{minutes: DUR_FOCUS_MIN, seconds: 7'd0};
      durations[1]       <= '{minutes: DUR_SHORT_MIN, seconds: 7'd0};
      durations[2]       <= '{minutes: DUR_LONG_MIN, seconds: 7'd0};
      digits[0]          <= mod10(7'd0);
      digits[1]          <= div10(7'd0);
      digits[2]          <= mod10(DUR_FOCUS_MIN);
      digits[3]          <= div10(DUR_FOCUS_MIN);
      edit_index         <= EDIT_TOP;
      tally              <= 4'd0;
      last_next_touch    <= 32'd0;
      last_inc_touch     <= 32'd0;
      out_valid          <= 1'b0;
    end else begin
      if (step) begin
        mode            <= mode_next;
        phase           <= phase_next;
        count_minutes   <= count_minutes_next;
        count_seconds   <= count_seconds_next;
        durations       <= durations_next;
        digits          <= digits_next;
        edit_index      <= edit_index_next;
        tally           <= tally_next;
        last_next_touch <= last_next_touch_next;
        last_inc_touch  <= last_inc_touch_next;
      end
      if (advance) begin
        out_valid <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_result <= result_next;
    end
  end

`ifndef SYNTHESIS
  a_finish_restarts: assert property (@(posedge clk) disable iff (rst)
    (step && mode == MODE_FINISHED && item_cmd != CMD_TICK) |=> (mode == MODE_TIMER))
    else $error("finished mode did not restart the timer");

  a_idle_tick_holds: assert property (@(posedge clk) disable iff (rst)
    (step && mode != MODE_TIMER && item_cmd == CMD_TICK)
      |=> ($stable(count_minutes) && $stable(count_seconds) && $stable(phase)))
    else $error("tick outside timer mode changed the state");

  a_changed_flag: assert property (@(posedge clk) disable iff (rst)
    step |=> (out_result.mode_changed ==
              ((mode != $past(mode)) || (phase != $past(phase)))))
    else $error("mode_changed disagrees with the state update");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    step |=> (out_result.run_mode == mode && out_result.edit_position == edit_index))
    else $error("result register out of step with the state");
`endif

endmodule

// ===== sv/pomodoro_countdown_controller_top.sv =====
`timescale 1ns / 1ps

// Pomodoro countdown controller. Each input item is one event (tuser: 0 second
// tick, 1 start/pause button, 2 next-digit touch, 3 increment-digit touch) with a
// millisecond time stamp in tdata; each accepted item gives exactly one result
// item with the run mode, phase, remaining count, edit digits and a flag for a
// mode or phase change. One item is taken every clock cycle unless tready is
// low on the result side: the whole state update is a single combinational
// pass between the input register and the result register. Debounce time and
// the number of short breaks before a long one are set over the APB port (0x0
// and 0x4); the user must write them only while no item is in flight, which
// the block itself does not enforce.

module pomodoro_countdown_controller_top import pcc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] time_ms
  input  logic [1:0]  s_tuser,   // [1:0] cmd
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  // [1:0] run_mode, [3:2] phase, [10:4] minutes_left, [17:11] seconds_left,
  // [24:18] edit_minutes, [31:25] edit_seconds, [33:32] edit_position,
  // [34] mode_changed, [39:35] zero
  output logic [39:0] m_tdata,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t        cfg;
  logic        advance;
  logic        item_valid;
  cmd_t        item_cmd;
  logic [31:0] item_time;
  result_t     result;

  pcc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register; frees whenever the core moves on
  pcc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tuser    (s_tuser),
    .s_tdata    (s_tdata),
    .advance    (advance),
    .item_valid (item_valid),
    .item_cmd   (item_cmd),
    .item_time  (item_time)
  );

  // state update and result register
  pcc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_cmd   (item_cmd),
    .item_time  (item_time),
    .advance    (advance),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (result)
  );

  assign m_tdata = {5'd0,
                    result.mode_changed,
                    result.edit_position,
                    result.edit_seconds,
                    result.edit_minutes,
                    result.seconds_left,
                    result.minutes_left,
                    result.phase,
                    result.run_mode};

endmodule
